FILE: src/sketch_stream_decoder_core_macros.svh
// Assertion helpers shared by the RTL.
`ifndef SKETCH_STREAM_DECODER_CORE_MACROS_SVH
`define SKETCH_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SSDEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SSDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ssdec_pkg.sv
`default_nettype none

package ssdec_pkg;

    localparam logic [3:0] MAX_KEY_BYTES   = 4'd3;
    localparam logic [3:0] MAX_COUNT_BYTES = 4'd10;

    localparam logic [7:0] FORMAT_VERSION = 8'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_NONFINITE = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_NO_BUCKET = 3'd5;

    localparam logic [31:0] GAMMA_ONE = 32'h3F80_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        has_bucket;
        logic [15:0] bin_key;
        logic [63:0] bin_count;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] gamma_bits;
        logic [31:0] sum_bits;
        logic [63:0] total_count;
    } t_out_item;

endpackage

`default_nettype wire

FILE: src/sketch_stream_decoder_core.sv
// Serialized quantile-sketch parser, one byte per transaction. Every byte updates the parser
// state in the cycle it is accepted, so a byte can be taken on every clock; a result (a finished
// bucket, the final status on the byte flagged last, or both in one) is registered as its byte
// is accepted. Results pass through a two-entry output buffer: o_in_ready stays high
// while at least one entry is free, so input only pauses after the output side has stalled for
// two results. After an error, bytes are consumed silently until the last byte reports the error
// code; the last byte always returns the parser to its reset state for the next sketch.
`default_nettype none

`include "sketch_stream_decoder_core_macros.svh"

module sketch_stream_decoder_core
    import ssdec_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam logic [2:0] PH_VERSION = 3'd0;
    localparam logic [2:0] PH_GAMMA   = 3'd1;
    localparam logic [2:0] PH_SUM     = 3'd2;
    localparam logic [2:0] PH_COUNT   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_BCOUNT  = 3'd5;

    logic [2:0]  r_phase,    n_phase;
    logic [3:0]  r_idx,      n_idx;
    logic [63:0] r_acc,      n_acc;
    logic [7:0]  r_version,  n_version;
    logic [31:0] r_gamma,    n_gamma;
    logic [31:0] r_sum,      n_sum;
    logic [63:0] r_hcount,   n_hcount;
    logic [15:0] r_last_key, n_last_key;
    logic [15:0] r_pend_key, n_pend_key;
    logic        r_saw,      n_saw;
    logic [2:0]  r_err,      n_err;

    logic        r_out_valid;
    t_out_item   r_out;
    logic        r_skid_valid;
    t_out_item   r_skid;

    logic        in_acc;
    logic        out_pop;
    logic        res_push;
    t_out_item   res;

    logic [7:0]  b;
    logic [3:0]  idx_inc;
    logic [6:0]  vi_shift;
    logic [63:0] vi_acc;
    logic [3:0]  vi_max;
    logic        vi_end;
    logic        vi_long;
    logic [31:0] fl_word;
    logic        emit;
    logic [15:0] key;
    logic [2:0]  st;

    assign o_in_ready  = !r_skid_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_pop     = r_out_valid && i_out_ready;

    assign b        = i_in_item.data_byte;
    assign idx_inc  = r_idx + 4'd1;
    // 7 * index
    assign vi_shift = {r_idx, 3'b000} - {3'b000, r_idx};
    assign vi_acc   = (r_idx <= 4'd9) ? (r_acc | ({57'b0, b[6:0]} << vi_shift)) : r_acc;
    assign vi_max   = (r_phase == PH_KEY) ? MAX_KEY_BYTES : MAX_COUNT_BYTES;
    assign vi_end   = !b[7];
    assign vi_long  = b[7] && (idx_inc >= vi_max);
    assign fl_word  = ((r_phase == PH_GAMMA) ? r_gamma : r_sum)
                      | ({24'b0, b} << {r_idx[1:0], 3'b000});
    assign key      = r_last_key + r_pend_key;

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_acc      = r_acc;
        n_version  = r_version;
        n_gamma    = r_gamma;
        n_sum      = r_sum;
        n_hcount   = r_hcount;
        n_last_key = r_last_key;
        n_pend_key = r_pend_key;
        n_saw      = r_saw;
        n_err      = r_err;
        emit       = 1'b0;
        st         = ST_OK;

        if (r_err == ST_OK) begin
            case (r_phase)
                PH_VERSION: begin
                    n_version = b;
                    n_idx     = 4'd0;
                    n_phase   = PH_GAMMA;
                end
                PH_GAMMA, PH_SUM: begin
                    if (r_phase == PH_GAMMA) begin
                        n_gamma = fl_word;
                    end else begin
                        n_sum = fl_word;
                    end
                    n_idx = idx_inc;
                    if (idx_inc >= 4'd4) begin
                        n_idx = 4'd0;
                        n_acc = '0;
                        if (fl_word[30:23] == 8'hFF) begin
                            n_err = ST_NONFINITE;
                        end else begin
                            n_phase = (r_phase == PH_GAMMA) ? PH_SUM : PH_COUNT;
                        end
                    end
                end
                PH_COUNT, PH_KEY, PH_BCOUNT: begin
                    n_acc = vi_acc;
                    n_idx = idx_inc;
                    if (vi_end) begin
                        n_idx = 4'd0;
                        n_acc = '0;
                        case (r_phase)
                            PH_COUNT: begin
                                n_hcount = vi_acc;
                                if (r_version != FORMAT_VERSION || r_gamma[31] ||
                                    r_gamma <= GAMMA_ONE || vi_acc == 64'd0) begin
                                    n_err = ST_BAD_HDR;
                                end else begin
                                    n_phase = PH_KEY;
                                end
                            end
                            PH_KEY: begin
                                n_pend_key = vi_acc[15:0];
                                n_phase    = PH_BCOUNT;
                            end
                            default: begin
                                n_last_key = key;
                                n_saw      = 1'b1;
                                emit       = 1'b1;
                                n_phase    = PH_KEY;
                            end
                        endcase
                    end else if (vi_long) begin
                        n_err = ST_TOO_LONG;
                    end
                end
                default: begin
                    n_phase = PH_VERSION;
                end
            endcase
        end

        // final status from the state after this byte
        if (n_err != ST_OK) begin
            st = n_err;
        end else if (n_phase != PH_KEY || n_idx != 4'd0) begin
            st = ST_TRUNCATED;
        end else if (!n_saw) begin
            st = ST_NO_BUCKET;
        end else begin
            st = ST_OK;
        end

        res.has_bucket   = emit;
        res.bin_key      = emit ? key : 16'd0;
        res.bin_count    = emit ? vi_acc : 64'd0;
        res.done_res     = i_in_item.last_byte;
        res.status       = i_in_item.last_byte ? st : ST_OK;
        res.gamma_bits   = i_in_item.last_byte ? n_gamma : 32'd0;
        res.sum_bits     = i_in_item.last_byte ? n_sum : 32'd0;
        res.total_count  = i_in_item.last_byte ? n_hcount : 64'd0;

        if (i_in_item.last_byte) begin
            n_phase    = PH_VERSION;
            n_idx      = 4'd0;
            n_acc      = '0;
            n_version  = '0;
            n_gamma    = '0;
            n_sum      = '0;
            n_hcount   = '0;
            n_last_key = '0;
            n_pend_key = '0;
            n_saw      = 1'b0;
            n_err      = ST_OK;
        end
    end

    assign res_push = in_acc && (emit || i_in_item.last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_VERSION;
            r_idx      <= '0;
            r_acc      <= '0;
            r_version  <= '0;
            r_gamma    <= '0;
            r_sum      <= '0;
            r_hcount   <= '0;
            r_last_key <= '0;
            r_pend_key <= '0;
            r_saw      <= 1'b0;
            r_err      <= ST_OK;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_acc      <= n_acc;
            r_version  <= n_version;
            r_gamma    <= n_gamma;
            r_sum      <= n_sum;
            r_hcount   <= n_hcount;
            r_last_key <= n_last_key;
            r_pend_key <= n_pend_key;
            r_saw      <= n_saw;
            r_err      <= n_err;
        end
    end

    // two-entry output buffer: main register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !out_pop) begin
            if (res_push) begin
                r_skid_valid <= 1'b1;
            end
        end else begin
            r_out_valid <= res_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (r_out_valid && !out_pop) begin
            if (res_push) begin
                r_skid <= res;
            end
        end else if (res_push) begin
            r_out <= res;
        end
    end

    `SSDEC_ASSERT_NOW(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held while main entry empty")
    `SSDEC_ASSERT_NOW(a_no_bucket_after_err, i_clk, i_rst_n, in_acc && (r_err != ST_OK),
        !emit, "bucket emitted after error")
    `SSDEC_ASSERT_NEXT(a_last_resets, i_clk, i_rst_n, in_acc && i_in_item.last_byte,
        (r_phase == PH_VERSION) && (r_err == ST_OK) && !r_saw, "parser not reset after last byte")
    `SSDEC_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= MAX_COUNT_BYTES,
        "byte index out of range")
    `SSDEC_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, res_push && !r_out_valid, o_out_valid,
        "pushed result not presented")

endmodule

`default_nettype wire
